### rtl/core/bfdh_pkg.sv
// Shared types, constants and hash step functions for the Bloom filter block.
// Used by every module under rtl/core; depends on nothing else.
package bfdh_pkg;

    localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 17;
    localparam int HCOUNT_W    = 5;
    localparam logic [CFG_DATA_W-1:0] FBU_RESET = 17'd65536;
    localparam logic [HCOUNT_W-1:0]   HCOUNT_RESET = 5'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_BITS_USED = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 8'd1;

    // One finished key on its way from the hashing front to the probe engine.
    typedef struct packed {
        logic        is_check;
        logic [63:0] ha;
        logic [63:0] hb;
    } key_job_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ACCESS,
        ST_NEXT,
        ST_RESULT
    } back_state_t;

    // FNV-1a step; the prime is 2^40 + 0x1b3, so the product is a shift and a small multiply.
    function automatic logic [63:0] hash_a_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x * 64'h1b3);
    endfunction

    // Multiply by 2^24 + 0x193, then XOR in the byte.
    function automatic logic [63:0] hash_b_step(input logic [63:0] h, input logic [7:0] b);
        return ((h << 24) + (h * 64'h193)) ^ {56'd0, b};
    endfunction

endpackage

### rtl/core/bloom_filter_double_hash.sv
// Top level of the Bloom filter: configuration registers, hashing front, job queue
// and probe engine. Depends on bfdh_pkg, bfdh_front, bfdh_queue and bfdh_back.
//
// Key bytes are taken one per cycle while in_ready is high (the queue has room and the
// bit store is not being cleared); an item with last_byte set ends the key, and one
// result follows it. In the probe engine each key runs k probes, each a bit-serial 64-bit
// remainder followed by a store access; the two-entry queue lets the next keys hash
// meanwhile. After reset the bit store is cleared one bit a cycle, during which no item
// is taken; configuration writes are taken at all times.
module bloom_filter_double_hash #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_HASHES  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [7:0]                        key_byte,
    input  logic                              has_byte,
    input  logic                              last_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              done_kind,
    output logic                              present,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfdh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bfdh_pkg::*;

    logic [CFG_DATA_W-1:0] fbu_reg;
    logic [HCOUNT_W-1:0]   hcount_reg;
    logic                  q_ready;
    logic                  q_valid;
    logic                  q_push;
    logic                  pop;
    logic                  clearing;
    key_job_t              q_job;
    key_job_t              head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fbu_reg    <= FBU_RESET;
            hcount_reg <= HCOUNT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FILTER_BITS_USED)
                fbu_reg <= cfg_data;
            else if (cfg_index == REG_HASH_COUNT)
                hcount_reg <= cfg_data[HCOUNT_W-1:0];
        end
    end

    bfdh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .key_byte  (key_byte),
        .has_byte  (has_byte),
        .last_byte (last_byte),
        .hold      (clearing),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    bfdh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    bfdh_back #(
        .FILTER_BITS (FILTER_BITS),
        .MAX_HASHES  (MAX_HASHES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .filter_bits_used (fbu_reg),
        .hash_count       (hcount_reg),
        .q_valid          (q_valid),
        .head             (head),
        .pop              (pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .done_kind        (done_kind),
        .present          (present)
    );

endmodule

### rtl/core/bfdh_front.sv
// Hashing front: takes key bytes, keeps both running hashes, emits one job per key.
// Depends on bfdh_pkg.
module bfdh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [7:0]         key_byte,
    input  logic               has_byte,
    input  logic               last_byte,
    input  logic               hold,
    input  logic               q_ready,
    output logic               q_push,
    output bfdh_pkg::key_job_t q_job
);
    import bfdh_pkg::*;

    logic [63:0] ha_reg;
    logic [63:0] ha_next;
    logic [63:0] hb_reg;
    logic [63:0] hb_next;
    logic        accept;

    assign in_ready = q_ready && !hold;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && last_byte;

    always_comb
    begin
        ha_next = has_byte ? hash_a_step(ha_reg, key_byte) : ha_reg;
        hb_next = has_byte ? hash_b_step(hb_reg, key_byte) : hb_reg;
    end

    assign q_job = '{is_check: req_type, ha: ha_next, hb: hb_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ha_reg <= OFFSET_BASIS;
            hb_reg <= OFFSET_BASIS;
        end
        else if (accept)
        begin
            ha_reg <= last_byte ? OFFSET_BASIS : ha_next;
            hb_reg <= last_byte ? OFFSET_BASIS : hb_next;
        end
    end

endmodule

### rtl/core/bfdh_queue.sv
// Two-entry job queue between the hashing front and the probe engine.
// Depends on bfdh_pkg.
module bfdh_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bfdh_pkg::key_job_t push_job,
    output logic               q_ready,
    input  logic               pop,
    output logic               q_valid,
    output bfdh_pkg::key_job_t head
);
    import bfdh_pkg::*;

    key_job_t    entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/core/bfdh_back.sv
// Probe engine: clears the bit store after reset, then runs the k probes of each key
// through a bit-serial remainder unit and the bit store. Depends on bfdh_pkg.
module bfdh_back #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_HASHES  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]    filter_bits_used,
    input  logic [bfdh_pkg::HCOUNT_W-1:0]      hash_count,
    input  logic                               q_valid,
    input  bfdh_pkg::key_job_t                 head,
    output logic                               pop,
    output logic                               clearing,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               done_kind,
    output logic                               present
);
    import bfdh_pkg::*;

    localparam int AW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1;
    localparam int MW = $clog2(FILTER_BITS + 1);
    localparam int KW = $clog2(MAX_HASHES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FILTER_BITS - 1);

    back_state_t   state_reg;
    back_state_t   state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [63:0]   acc_reg;
    logic [63:0]   step_reg;
    logic [MW-1:0] rem_reg;
    logic [MW-1:0] rem_next;
    logic [MW-1:0] m_reg;
    logic [MW-1:0] m_eff;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_eff;
    logic [KW-1:0] probe_reg;
    logic [5:0]    bit_cnt_reg;
    logic          all_set_reg;
    logic          out_valid_reg;
    logic          kind_reg;
    logic          present_reg;
    logic          out_load;
    logic          mem_we;
    logic          mem_wd;
    logic [AW-1:0] mem_addr;
    logic          rd_data_reg;
    logic          bit_store [FILTER_BITS];
    logic [MW:0]   trial;

    assign out_valid = out_valid_reg;
    assign done_kind = kind_reg;
    assign present   = present_reg;
    assign clearing  = (state_reg == ST_CLEAR);

    // Out-of-range modulus and probe count fall back to the full size.
    always_comb
    begin
        if (filter_bits_used == '0 || 32'(filter_bits_used) > FILTER_BITS)
            m_eff = MW'(FILTER_BITS);
        else
            m_eff = MW'(filter_bits_used);
        if (32'(hash_count) > MAX_HASHES)
            k_eff = KW'(MAX_HASHES);
        else
            k_eff = KW'(hash_count);
    end

    // One restoring step of the 64-bit remainder, MSB first.
    always_comb
    begin
        trial = {rem_reg, acc_reg[bit_cnt_reg]};
        if (trial >= {1'b0, m_reg})
            rem_next = MW'(trial - {1'b0, m_reg});
        else
            rem_next = trial[MW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:   if (q_valid) state_next = (k_eff == '0) ? ST_RESULT : ST_DIV;
            ST_DIV:    if (bit_cnt_reg == 6'd0) state_next = ST_ACCESS;
            ST_ACCESS: state_next = ST_NEXT;
            ST_NEXT:   state_next = (probe_reg + KW'(1) == k_reg) ? ST_RESULT : ST_DIV;
            ST_RESULT: if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we   = 1'b0;
        mem_wd   = 1'b0;
        mem_addr = rem_reg[AW-1:0];
        pop      = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            ST_ACCESS:
            begin
                mem_we = !head.is_check;
                mem_wd = 1'b1;
            end
            ST_RESULT:
            begin
                out_load = !out_valid_reg || out_ready;
                pop      = out_load;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                acc_reg     <= head.ha;
                step_reg    <= head.hb;
                m_reg       <= m_eff;
                k_reg       <= k_eff;
                probe_reg   <= '0;
                all_set_reg <= 1'b1;
                rem_reg     <= '0;
                bit_cnt_reg <= 6'd63;
            end
            ST_DIV:
            begin
                rem_reg     <= rem_next;
                bit_cnt_reg <= bit_cnt_reg - 6'd1;
            end
            ST_NEXT:
            begin
                if (head.is_check && !rd_data_reg)
                    all_set_reg <= 1'b0;
                acc_reg     <= acc_reg + step_reg;
                probe_reg   <= probe_reg + KW'(1);
                rem_reg     <= '0;
                bit_cnt_reg <= 6'd63;
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    kind_reg    <= head.is_check;
                    present_reg <= head.is_check && all_set_reg;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bit_store[mem_addr] <= mem_wd;
        rd_data_reg <= bit_store[mem_addr];
    end

    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("probe engine retired a job from an empty queue");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS) |-> (rem_reg < m_reg))
        else $error("probe position not below the modulus");

    a_next_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEXT) |-> ($past(state_reg) == ST_ACCESS))
        else $error("probe step without a store access");

endmodule
